// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define AST_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/gvbl_pkg.sv -----
// Shared types and constants for the greedy victim bucket list block.
package gvbl_pkg;

  localparam int DIES_DEF           = 8;
  localparam int BLOCKS_PER_DIE_DEF = 1024;
  localparam int SLICES_DEF         = 256;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2
  } gvbl_kind_t;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    gvbl_kind_t  kind;
    logic [2:0]  die;
    logic [9:0]  block;
    logic [8:0]  bucket;
  } gvbl_req_t;

  typedef struct packed {
    logic [9:0]  victim;
    logic        status;
  } gvbl_res_t;

endpackage

// ----- sv/greedy_victim_bucket_lists_core.sv -----
// Requests are handled one at a time: in_tready rises again only after the result of
// the last one has moved into the output slot. A pop reads bucket heads from SLICES
// down to the first non-empty one and reports empty if none down to bucket 1 holds a
// block; an insert onto a non-empty bucket adds a step that links the old tail forward.
// Reset: synchronous, active low; afterwards a clearing pass writes every bucket head
// and tail, DIES*(SLICES+1) entries (2056 by default), with in_tready low.
module greedy_victim_bucket_lists_core import gvbl_pkg::*; #(
  parameter int DIES           = DIES_DEF,
  parameter int BLOCKS_PER_DIE = BLOCKS_PER_DIE_DEF,
  parameter int SLICES         = SLICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // die [2:0], block [12:3], bucket [21:13], zero pad
  input  logic [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // victim [9:0], zero pad
  output logic        out_tuser   // status
);

  gvbl_req_t  req;
  gvbl_res_t  res;
  logic       res_valid, res_ready;
  logic       out_valid_r, out_valid_nxt;
  gvbl_res_t  out_res_r, out_res_nxt;

  assign req = '{kind:   gvbl_kind_t'(in_tuser),
                 die:    in_tdata[2:0],
                 block:  in_tdata[12:3],
                 bucket: in_tdata[21:13]};

  gvbl_engine #(
    .DIES           (DIES),
    .BLOCKS_PER_DIE (BLOCKS_PER_DIE),
    .SLICES         (SLICES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output slot frees when empty or taken this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.victim};
  assign out_tuser  = out_res_r.status;

endmodule

// ----- sv/gvbl_engine.sv -----
// Sequencer and list memories: insert, pop and remove on the per-die buckets.
module gvbl_engine import gvbl_pkg::*; #(
  parameter int DIES           = DIES_DEF,
  parameter int BLOCKS_PER_DIE = BLOCKS_PER_DIE_DEF,
  parameter int SLICES         = SLICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  gvbl_req_t req,
  output logic      req_ready,
  output logic      res_valid,
  output gvbl_res_t res,
  input  logic      res_ready
);

  localparam int BUCKETS = SLICES + 1;
  localparam int NBKT    = DIES * BUCKETS;
  localparam int NLNK    = DIES * BLOCKS_PER_DIE;
  localparam int BKT_AW  = (NBKT > 1) ? $clog2(NBKT) : 1;
  localparam int LNK_AW  = $clog2(NLNK);
  localparam int LW      = $clog2(BLOCKS_PER_DIE + 1);
  localparam int BIDX_W  = $clog2(SLICES + 1);
  localparam logic [LW-1:0]     NONE     = LW'(BLOCKS_PER_DIE);
  localparam logic [BKT_AW-1:0] CLR_LAST = BKT_AW'(NBKT - 1);

  typedef enum logic [10:0] {
    S_CLR      = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_INS_RD   = 11'b000_0000_0100,
    S_INS_WR   = 11'b000_0000_1000,
    S_INS_LINK = 11'b000_0001_0000,
    S_RM_RD    = 11'b000_0010_0000,
    S_RM_WR    = 11'b000_0100_0000,
    S_POP_SCAN = 11'b000_1000_0000,
    S_POP_NX   = 11'b001_0000_0000,
    S_POP_WR   = 11'b010_0000_0000,
    S_FIN      = 11'b100_0000_0000
  } eng_state_t;

  eng_state_t state_r, state_nxt;
  logic [BKT_AW-1:0] clr_r, clr_nxt;
  logic [BKT_AW-1:0] bkt_base_r, bkt_base_nxt;
  logic [LNK_AW-1:0] lnk_base_r, lnk_base_nxt;
  logic [LW-1:0]     blk_r, blk_nxt;
  logic [LW-1:0]     oth_r, oth_nxt;
  logic [BIDX_W-1:0] bucket_r, bucket_nxt;
  logic [BIDX_W-1:0] scan_b_r, scan_b_nxt;
  logic [BIDX_W-1:0] chk_b_r, chk_b_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [9:0]        vic_r, vic_nxt;
  logic              sts_r, sts_nxt;

  logic [LW-1:0] head_mem [NBKT];
  logic [LW-1:0] tail_mem [NBKT];
  logic [LW-1:0] next_mem [NLNK];
  logic [LW-1:0] prev_mem [NLNK];
  logic [LW-1:0] head_q, tail_q, nx_q, pv_q;

  logic              hd_we, tl_we, nl_we, pl_we;
  logic [BKT_AW-1:0] hd_ra, bkt_addr, hd_wa, tl_wa;
  logic [LW-1:0]     hd_wd, tl_wd, nl_wd, pl_wd;
  logic [LNK_AW-1:0] lnk_ra, nl_wa, pl_wa;

  logic        die_ok, args_ok, has_next, has_prev, tail_used;
  logic [31:0] req_blk32, req_bkt32, blk32;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = '{victim: vic_r, status: sts_r};

  assign bkt_addr  = bkt_base_r + BKT_AW'(bucket_r);
  assign lnk_ra    = lnk_base_r + LNK_AW'(blk_r);
  assign hd_ra     = (state_r == S_POP_SCAN) ? bkt_base_r + BKT_AW'(scan_b_r) : bkt_addr;

  assign req_blk32 = 32'(req.block);
  assign req_bkt32 = 32'(req.bucket);
  assign blk32     = 32'(blk_r);
  assign die_ok    = 32'(req.die) < DIES;
  assign args_ok   = die_ok && (req_blk32 < BLOCKS_PER_DIE) && (req_bkt32 <= SLICES);
  assign has_next  = nx_q < NONE;
  assign has_prev  = pv_q < NONE;
  assign tail_used = tail_q < NONE;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    bkt_base_nxt = bkt_base_r;
    lnk_base_nxt = lnk_base_r;
    blk_nxt      = blk_r;
    oth_nxt      = oth_r;
    bucket_nxt   = bucket_r;
    scan_b_nxt   = scan_b_r;
    chk_b_nxt    = chk_b_r;
    chk_v_nxt    = chk_v_r;
    vic_nxt      = vic_r;
    sts_nxt      = sts_r;
    hd_we = 1'b0;  hd_wa = bkt_addr;  hd_wd = NONE;
    tl_we = 1'b0;  tl_wa = bkt_addr;  tl_wd = NONE;
    nl_we = 1'b0;  nl_wa = lnk_ra;    nl_wd = NONE;
    pl_we = 1'b0;  pl_wa = lnk_ra;    pl_wd = NONE;
    case (state_r)
      S_CLR: begin
        hd_we = 1'b1;
        tl_we = 1'b1;
        hd_wa = clr_r;
        tl_wa = clr_r;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          bkt_base_nxt = BKT_AW'(32'(req.die) * BUCKETS);
          lnk_base_nxt = LNK_AW'(32'(req.die) * BLOCKS_PER_DIE);
          blk_nxt      = req_blk32[LW-1:0];
          bucket_nxt   = req_bkt32[BIDX_W-1:0];
          scan_b_nxt   = BIDX_W'(SLICES);
          chk_v_nxt    = 1'b0;
          vic_nxt      = '0;
          sts_nxt      = STATUS_DONE;
          case (req.kind)
            KIND_INSERT: state_nxt = args_ok ? S_INS_RD : S_FIN;
            KIND_REMOVE: state_nxt = args_ok ? S_RM_RD : S_FIN;
            KIND_POP: begin
              if (die_ok) begin
                state_nxt = S_POP_SCAN;
              end else begin
                sts_nxt   = STATUS_EMPTY;
                state_nxt = S_FIN;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_INS_RD: state_nxt = S_INS_WR;
      S_INS_WR: begin
        // new block becomes the tail; link the old tail forward in the next step
        pl_we   = 1'b1;
        pl_wd   = tail_used ? tail_q : NONE;
        nl_we   = 1'b1;
        tl_we   = 1'b1;
        tl_wd   = blk_r;
        hd_we   = !tail_used;
        hd_wd   = blk_r;
        oth_nxt = tail_q;
        state_nxt = tail_used ? S_INS_LINK : S_FIN;
      end
      S_INS_LINK: begin
        nl_we = 1'b1;
        nl_wa = lnk_base_r + LNK_AW'(oth_r);
        nl_wd = blk_r;
        state_nxt = S_FIN;
      end
      S_RM_RD: state_nxt = S_RM_WR;
      S_RM_WR: begin
        nl_wa = lnk_base_r + LNK_AW'(pv_q);
        pl_wa = lnk_base_r + LNK_AW'(nx_q);
        if (has_next && has_prev) begin
          nl_we = 1'b1;
          nl_wd = nx_q;
          pl_we = 1'b1;
          pl_wd = pv_q;
        end else if (has_prev) begin
          nl_we = 1'b1;
          tl_we = 1'b1;
          tl_wd = pv_q;
        end else if (has_next) begin
          pl_we = 1'b1;
          hd_we = 1'b1;
          hd_wd = nx_q;
        end else begin
          hd_we = 1'b1;
          tl_we = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_POP_SCAN: begin
        // head read for one bucket is in flight while the previous one is checked
        if (chk_v_r && (head_q < NONE)) begin
          bucket_nxt = chk_b_r;
          blk_nxt    = head_q;
          state_nxt  = S_POP_NX;
        end else if (chk_v_r && (chk_b_r == BIDX_W'(1))) begin
          sts_nxt   = STATUS_EMPTY;
          state_nxt = S_FIN;
        end else begin
          chk_v_nxt  = 1'b1;
          chk_b_nxt  = scan_b_r;
          scan_b_nxt = scan_b_r - 1'b1;
        end
      end
      S_POP_NX: state_nxt = S_POP_WR;
      S_POP_WR: begin
        hd_we = 1'b1;
        if (has_next) begin
          pl_we = 1'b1;
          pl_wa = lnk_base_r + LNK_AW'(nx_q);
          hd_wd = nx_q;
        end else begin
          tl_we = 1'b1;
        end
        vic_nxt   = blk32[9:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bkt_base_r <= bkt_base_nxt;
    lnk_base_r <= lnk_base_nxt;
    blk_r      <= blk_nxt;
    oth_r      <= oth_nxt;
    bucket_r   <= bucket_nxt;
    scan_b_r   <= scan_b_nxt;
    chk_b_r    <= chk_b_nxt;
    vic_r      <= vic_nxt;
    sts_r      <= sts_nxt;
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    head_q <= head_mem[hd_ra];
  end

  always_ff @(posedge clk) begin
    if (tl_we) begin
      tail_mem[tl_wa] <= tl_wd;
    end
    tail_q <= tail_mem[bkt_addr];
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      next_mem[nl_wa] <= nl_wd;
    end
    nx_q <= next_mem[lnk_ra];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      prev_mem[pl_wa] <= pl_wd;
    end
    pv_q <= prev_mem[lnk_ra];
  end

endmodule

// ----- sv/gvbl_checker.sv -----
// Port-level checks for the bucket list core, bound to the top level.
`include "assert_macros.svh"

module gvbl_checker import gvbl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result stays offered
  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its payload
  `AST_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready,
            $stable(out_tdata) && $stable(out_tuser))

  // one request at a time: ready drops right after an accept
  `AST_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // an empty pop never carries a victim
  `AST_SAME(a_empty_no_victim, clk, rst_n, out_tvalid && (out_tuser == STATUS_EMPTY),
            out_tdata == 16'd0)

endmodule

bind greedy_victim_bucket_lists_core gvbl_checker u_gvbl_checker (.*);
